// ----- hdl/qpd_pkg.sv -----
// Package for the quoted-printable byte decoder: item and result types,
// the decode phase encoding, character constants and the hex digit lookup.
// No dependencies.
package qpd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned NibW  = 4;

  localparam logic [ByteW-1:0] EscResetVal = 8'd61;  // '='
  localparam logic [ByteW-1:0] ChCr        = 8'h0D;
  localparam logic [ByteW-1:0] ChLf        = 8'h0A;
  localparam logic [ByteW-1:0] ChUpperA    = 8'h41;  // 'A'
  localparam logic [ByteW-1:0] ChLowerA    = 8'h61;  // 'a'
  localparam logic [ByteW-1:0] ChZero      = 8'h30;  // '0'
  localparam logic [ByteW-1:0] HexTen      = 8'd10;

  // Decode phase, one-hot.
  typedef enum logic [3:0] {
    PH_NORMAL = 4'b0001,
    PH_ESC    = 4'b0010,
    PH_ESC_CR = 4'b0100,
    PH_LOW    = 4'b1000
  } phase_t;

  // One input transaction.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             valid;
    logic             error;
    logic             done;
  } res_t;

  // Hex digit lookup.
  typedef struct packed {
    logic            bad;
    logic [NibW-1:0] value;
  } hex_t;

  function automatic hex_t hex_value(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] diff;
    hex_t             h;
    h.bad   = 1'b0;
    h.value = '0;
    if (c inside {[8'h41:8'h46]}) begin
      diff    = c - ChUpperA + HexTen;
      h.value = diff[NibW-1:0];
    end else if (c inside {[8'h61:8'h66]}) begin
      diff    = c - ChLowerA + HexTen;
      h.value = diff[NibW-1:0];
    end else if (c inside {[8'h30:8'h39]}) begin
      diff    = c - ChZero;
      h.value = diff[NibW-1:0];
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

// ----- hdl/qpd_in_reg.sv -----
// Input register stage of the quoted-printable byte decoder.
// Depends on qpd_pkg for the item type.
module qpd_in_reg import qpd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  s1_valid,
  input  logic  s1_take,
  output item_t s1_item
);

  logic  valid_r;
  item_t item_r;

  // The stage takes a new transaction when it is empty or being drained.
  assign in_ready = !valid_r || s1_take;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- hdl/qpd_decode.sv -----
// Decode logic and string state of the quoted-printable byte decoder.
// Depends on qpd_pkg for types, phase codes and the hex lookup.
module qpd_decode import qpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [ByteW-1:0] escape_char,
  input  logic             fire,
  input  item_t            item,
  output res_t             res
);

  phase_t          phase_r, phase_nxt;
  logic [NibW-1:0] nib_r, nib_nxt;
  logic            err_r, err_nxt;
  logic            as_normal;
  logic [ByteW-1:0] obyte;
  logic            ovalid;
  hex_t            hx;

  assign hx = hex_value(item.data);

  // Phase update and output byte for the byte in the input register.
  always_comb begin
    phase_nxt = phase_r;
    nib_nxt   = nib_r;
    err_nxt   = err_r;
    as_normal = 1'b0;
    obyte     = '0;
    ovalid    = 1'b0;
    if (!err_r) begin
      case (phase_r)
        PH_NORMAL: begin
          as_normal = 1'b1;
        end
        PH_ESC: begin
          if (item.last) begin
            phase_nxt = PH_NORMAL;
          end else if (item.data == ChCr) begin
            phase_nxt = PH_ESC_CR;
          end else if (item.data == ChLf) begin
            phase_nxt = PH_NORMAL;
          end else if (hx.bad) begin
            err_nxt   = 1'b1;
            phase_nxt = PH_NORMAL;
          end else begin
            nib_nxt   = hx.value;
            phase_nxt = PH_LOW;
          end
        end
        PH_ESC_CR: begin
          phase_nxt = PH_NORMAL;
          as_normal = (item.data != ChLf);
        end
        PH_LOW: begin
          phase_nxt = PH_NORMAL;
          if (hx.bad) begin
            err_nxt = 1'b1;
          end else begin
            obyte  = {nib_r, hx.value};
            ovalid = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_NORMAL;
        end
      endcase
    end
    // Ordinary byte: either it opens an escape or it passes through.
    if (as_normal) begin
      if (item.data == escape_char) begin
        phase_nxt = PH_ESC;
      end else begin
        obyte  = item.data;
        ovalid = 1'b1;
      end
    end
  end

  assign res.data  = obyte;
  assign res.valid = ovalid;
  assign res.error = err_nxt;
  assign res.done  = item.last;

  // String state; everything returns to reset after the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      nib_r   <= '0;
      err_r   <= 1'b0;
    end else if (fire) begin
      if (item.last) begin
        phase_r <= PH_NORMAL;
        nib_r   <= '0;
        err_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        nib_r   <= nib_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

// ----- hdl/qpd_out_reg.sv -----
// Result register stage of the quoted-printable byte decoder.
// Depends on qpd_pkg for the result type.
module qpd_out_reg import qpd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load_valid,
  output logic load_ready,
  input  res_t load_res,
  output logic out_res_valid,
  input  logic out_res_ready,
  output res_t out_res
);

  logic valid_r;
  res_t res_r;

  // Loads when empty or when the held result leaves in this cycle.
  assign load_ready    = !valid_r || out_res_ready;
  assign out_res_valid = valid_r;
  assign out_res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule

// ----- hdl/quoted_printable_byte_decoder.sv -----
// Top level of the quoted-printable byte decoder: input register, decode
// logic with string state, result register. Depends on qpd_pkg and the qpd_ modules.
//
//   Channel  Handshake                      Payload
//   input    in_valid / in_ready            in_byte, in_last_byte
//   result   out_res_valid / out_res_ready  out_byte, out_valid,
//                                           out_decode_error, out_string_done
//   config   cfg_wr_en                      cfg_wr_data (escape character)
//
// One transaction in and one result out per cycle when neither side stalls.
// A result passes from the input register through the decode logic into the result register, where it shows.
// Reset returns the escape character to '=' and clears all string state.
// A stalled result holds in the result register while the input register
// still takes one more transaction; the decode state advances only when
// a byte moves from the input register into the result register.
module quoted_printable_byte_decoder import qpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_byte,
  input  logic             in_last_byte,
  output logic             out_res_valid,
  input  logic             out_res_ready,
  output logic [ByteW-1:0] out_byte,
  output logic             out_valid,
  output logic             out_decode_error,
  output logic             out_string_done,
  input  logic             cfg_wr_en,
  input  logic [ByteW-1:0] cfg_wr_data
);

  logic [ByteW-1:0] esc_r;
  item_t            in_item, s1_item;
  logic             s1_valid, load_ready, fire;
  res_t             dec_res, out_res;

  // Escape character register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= EscResetVal;
    end else if (cfg_wr_en) begin
      esc_r <= cfg_wr_data;
    end
  end

  assign in_item.data = in_byte;
  assign in_item.last = in_last_byte;
  assign fire         = s1_valid && load_ready;

  qpd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_take  (load_ready),
    .s1_item  (s1_item)
  );

  qpd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .escape_char (esc_r),
    .fire        (fire),
    .item        (s1_item),
    .res         (dec_res)
  );

  qpd_out_reg u_out_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .load_valid    (s1_valid),
    .load_ready    (load_ready),
    .load_res      (dec_res),
    .out_res_valid (out_res_valid),
    .out_res_ready (out_res_ready),
    .out_res       (out_res)
  );

  assign out_byte         = out_res.data;
  assign out_valid        = out_res.valid;
  assign out_decode_error = out_res.error;
  assign out_string_done  = out_res.done;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for quoted_printable_byte_decoder. It holds a scoreboard class
// that predicts each result from the accepted input bytes and checks the result channel.
// Depends on qpd_pkg and the RTL top level.
module tb import qpd_pkg::*;;

  localparam logic [ByteW-1:0] EscEquals  = 8'h3D;  // '='
  localparam logic [ByteW-1:0] EscPercent = 8'h25;  // '%'
  localparam int unsigned      IdleLimit  = 2000;
  localparam int unsigned      PhaseItems = 120;
  localparam int unsigned      MaxReports = 50;

  // Predicts the decoder result for every accepted input transaction and keeps
  // the expected results in arrival order.
  class qp_scoreboard;
    phase_t            phase;
    logic [NibW-1:0]   high_nib;
    logic              err_flag;
    logic [ByteW-1:0]  esc_char;
    res_t              expected[$];
    int unsigned       mismatches;

    function new();
      esc_char   = EscResetVal;
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      phase    = PH_NORMAL;
      high_nib = '0;
      err_flag = 1'b0;
    endfunction

    function void set_escape(logic [ByteW-1:0] v);
      esc_char = v;
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction

    // Bit 4 set means the byte is not a hex digit; otherwise bits 3:0 hold its value.
    function logic [4:0] digit_value(logic [ByteW-1:0] c);
      logic [ByteW-1:0] v;
      v = 8'd16;
      if (c >= ChUpperA && c <= ChUpperA + 8'd5) begin
        v = c - ChUpperA + HexTen;
      end else if (c >= ChLowerA && c <= ChLowerA + 8'd5) begin
        v = c - ChLowerA + HexTen;
      end else if (c >= ChZero && c <= ChZero + 8'd9) begin
        v = c - ChZero;
      end
      return v[4:0];
    endfunction

    // Advances the predicted string state by one byte and queues the result.
    function void note_input(logic [ByteW-1:0] b, logic last);
      res_t       r;
      logic       plain;
      logic [4:0] d;
      r     = '0;
      plain = 1'b0;
      if (!err_flag) begin
        case (phase)
          PH_NORMAL: plain = 1'b1;
          PH_ESC: begin
            if (last) begin
              phase = PH_NORMAL;
            end else if (b == ChCr) begin
              phase = PH_ESC_CR;
            end else if (b == ChLf) begin
              phase = PH_NORMAL;
            end else begin
              d = digit_value(b);
              if (d[4]) begin
                err_flag = 1'b1;
                phase    = PH_NORMAL;
              end else begin
                high_nib = d[3:0];
                phase    = PH_LOW;
              end
            end
          end
          PH_ESC_CR: begin
            phase = PH_NORMAL;
            plain = (b != ChLf);
          end
          default: begin
            d     = digit_value(b);
            phase = PH_NORMAL;
            if (d[4]) begin
              err_flag = 1'b1;
            end else begin
              r.data  = {high_nib, d[3:0]};
              r.valid = 1'b1;
            end
          end
        endcase
      end
      // An ordinary byte either opens an escape or passes straight through.
      if (plain) begin
        if (b == esc_char) begin
          phase = PH_ESC;
        end else begin
          r.data  = b;
          r.valid = 1'b1;
        end
      end
      r.error  = err_flag;
      r.done   = last;
      expected = {expected, r};
      if (last) begin
        clear_string();
      end
    endfunction

    task report(string msg);
      if (mismatches < MaxReports) begin
        $display("%0t mismatch: %s", $realtime, msg);
      end
      mismatches++;
    endtask

    // Compares one accepted result with the oldest expectation.
    task check_result(res_t got);
      res_t want;
      if (expected.size() == 0) begin
        report("result arrived with no transaction outstanding");
      end else begin
        want = expected.pop_front();
        if (got.data !== want.data) begin
          report($sformatf("out_byte got %h want %h", got.data, want.data));
        end
        if (got.valid !== want.valid) begin
          report($sformatf("out_valid got %b want %b", got.valid, want.valid));
        end
        if (got.error !== want.error) begin
          report($sformatf("out_decode_error got %b want %b", got.error, want.error));
        end
        if (got.done !== want.done) begin
          report($sformatf("out_string_done got %b want %b", got.done, want.done));
        end
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] in_byte = '0;
  logic             in_last_byte = 1'b0;
  logic             out_res_valid;
  logic             out_res_ready = 1'b0;
  logic [ByteW-1:0] out_byte;
  logic             out_valid;
  logic             out_decode_error;
  logic             out_string_done;
  logic             cfg_wr_en = 1'b0;
  logic [ByteW-1:0] cfg_wr_data = '0;

  qp_scoreboard     decoder_sb = new();
  bit               burst[2] = '{1'b0, 1'b0};
  logic [ByteW-1:0] text_q[$];
  int unsigned      idle_cycles = 0;

  quoted_printable_byte_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_last_byte     (in_last_byte),
    .out_res_valid    (out_res_valid),
    .out_res_ready    (out_res_ready),
    .out_byte         (out_byte),
    .out_valid        (out_valid),
    .out_decode_error (out_decode_error),
    .out_string_done  (out_string_done),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Wait before the next transaction on one side; now and then the side switches
  // between random gaps and back-to-back stretches.
  function int unsigned draw_wait(int side);
    if ($urandom_range(0, 31) == 0) begin
      burst[side] = !burst[side];
    end
    return burst[side] ? 0 : $urandom_range(0, 18);
  endfunction

  function logic [ByteW-1:0] rand_byte();
    return ByteW'($urandom_range(0, 255));
  endfunction

  function logic [ByteW-1:0] hex_char(logic [NibW-1:0] n, bit lower);
    if (n < 10) begin
      return ChZero + n;
    end
    return (lower ? ChLowerA : ChUpperA) + n - HexTen;
  endfunction

  // A random hex digit in either case.
  function logic [ByteW-1:0] rand_hex_char();
    return hex_char(NibW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endfunction

  function logic [ByteW-1:0] bad_digit();
    logic [ByteW-1:0] b;
    logic [4:0]       d;
    do begin
      b = rand_byte();
      d = decoder_sb.digit_value(b);
    end while (!d[4]);
    return b;
  endfunction

  function void append_byte(logic [ByteW-1:0] b);
    text_q = {text_q, b};
  endfunction

  // Appends one piece of encoded text: mostly well-formed escapes and plain bytes,
  // with some soft breaks, broken escapes and raw noise.
  function void add_piece(logic [ByteW-1:0] esc);
    int unsigned      pick;
    logic [ByteW-1:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      b = rand_byte();
      if (b == esc) begin
        b = b ^ 8'h01;
      end
      append_byte(b);
    end else if (pick < 65) begin
      append_byte(esc);
      append_byte(rand_hex_char());
      append_byte(rand_hex_char());
    end else if (pick < 73) begin
      append_byte(esc);
      append_byte(ChCr);
      append_byte(ChLf);
    end else if (pick < 78) begin
      append_byte(esc);
      append_byte(ChLf);
    end else if (pick < 83) begin
      append_byte(esc);
      append_byte(ChCr);
    end else if (pick < 90) begin
      append_byte(esc);
      if ($urandom_range(0, 1) == 1) begin
        append_byte(rand_hex_char());
      end
      append_byte(bad_digit());
    end else if (pick < 95) begin
      append_byte(esc);
    end else begin
      append_byte(rand_byte());
    end
  endfunction

  // Drives one input transaction and notes it once it is accepted.
  task automatic send_item(logic [ByteW-1:0] b, logic last);
    int unsigned gap;
    gap = draw_wait(0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    decoder_sb.note_input(b, last);
  endtask

  // Sends the bytes held in text_q; flag marks the final one as the end of a string.
  task automatic send_text(bit close_string);
    for (int i = 0; i < text_q.size(); i++) begin
      send_item(text_q[i], close_string && (i == text_q.size() - 1));
    end
  endtask

  task automatic send_random_strings(logic [ByteW-1:0] esc, int unsigned count);
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      text_q.delete();
      repeat ($urandom_range(1, 6)) add_piece(esc);
      send_text(1'b1);
      sent += text_q.size();
    end
  endtask

  // Stops input and lets every outstanding result drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (decoder_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_escape(logic [ByteW-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    decoder_sb.set_escape(v);
  endtask

  // Result side: random stalls, then every accepted result is checked.
  initial begin
    res_t got;
    while (!rst_n) @(posedge clk);
    forever begin
      int unsigned stall;
      stall = draw_wait(1);
      if (stall != 0) begin
        out_res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_res_ready <= 1'b1;
      do @(posedge clk); while (!out_res_valid);
      got.data  = out_byte;
      got.valid = out_valid;
      got.error = out_decode_error;
      got.done  = out_string_done;
      decoder_sb.check_result(got);
    end
  end

  // Ends the run if neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_res_valid && out_res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings with the reset escape character: byte extremes, mixed-case
    // digits, soft break, lone LF, CR followed by another escape, bad low digit with
    // suppression, escape as the last byte, escape followed by the last byte, and a
    // bad high digit.
    text_q = '{8'h00, EscEquals, "a", "F", EscEquals, ChCr, ChLf, EscEquals, ChLf, 8'hFF,
               EscEquals, ChCr, EscEquals, "0", "9", EscEquals, "9", "G", "z"};
    send_text(1'b1);
    text_q = '{EscEquals};
    send_text(1'b1);
    text_q = '{EscEquals, "A"};
    send_text(1'b1);
    text_q = '{EscEquals, "g", "q"};
    send_text(1'b1);
    send_random_strings(EscEquals, PhaseItems);

    // Random strings under several escape characters, the extremes among them.
    wait_idle();
    write_escape(EscPercent);
    send_random_strings(EscPercent, PhaseItems);
    wait_idle();
    write_escape(8'h00);
    send_random_strings(8'h00, PhaseItems);
    wait_idle();
    write_escape(8'hFF);
    send_random_strings(8'hFF, PhaseItems);
    wait_idle();
    begin
      logic [ByteW-1:0] any_esc;
      any_esc = rand_byte();
      write_escape(any_esc);
      send_random_strings(any_esc, PhaseItems);
    end
    wait_idle();
    write_escape(EscEquals);
    send_random_strings(EscEquals, PhaseItems);

    wait_idle();
    repeat (8) @(posedge clk);
    if (decoder_sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/qpd_pkg.sv
hdl/qpd_in_reg.sv
hdl/qpd_decode.sv
hdl/qpd_out_reg.sv
hdl/quoted_printable_byte_decoder.sv
tb/sv/tb.sv
